// ----- src/impulse_onset_align_top_macros.svh -----
// ----------------------------------------------------------------------------
// Impulse onset align assertion macros
// Concurrent assertion wrappers; define NO_ASSERTIONS to drop them.
// ----------------------------------------------------------------------------
`ifndef IMPULSE_ONSET_ALIGN_TOP_MACROS_SVH
`define IMPULSE_ONSET_ALIGN_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

`define IAO_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("impulse_onset_align assertion failed");

`define IAO_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("impulse_onset_align assertion failed");

`else

`define IAO_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define IAO_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- src/iao_pkg.sv -----
// ----------------------------------------------------------------------------
// Impulse onset align package
// Sizes, item types, memory request and sequencer states.
// ----------------------------------------------------------------------------
package iao_pkg;

    localparam int MAX_LEN  = 1024;
    localparam int TAPS     = 32;
    localparam int ADDR_W   = $clog2(MAX_LEN);
    localparam int CNT_W    = $clog2(MAX_LEN + 1);
    localparam int SRC_W    = $clog2(MAX_LEN + TAPS);
    localparam int TAP_W    = $clog2(TAPS + 1);
    localparam int ONSET_W  = 10;
    localparam int SAMPLE_W = 16;
    localparam int MAG_W    = SAMPLE_W + 1;
    localparam int PROD_W   = MAG_W + 4;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       final_sample;
    } t_in;

    typedef struct packed {
        logic                       is_onset;
        logic [ONSET_W-1:0]         onset_index;
        logic signed [SAMPLE_W-1:0] tap;
        logic                       overflow;
        logic                       end_of_run;
    } t_out;

    typedef struct packed {
        logic                       we;
        logic [ADDR_W-1:0]          waddr;
        logic [SAMPLE_W-1:0]        wdata;
        logic [ADDR_W-1:0]          raddr;
    } t_mem_req;

    typedef enum logic [2:0] {
        S_LOAD,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_ONSET,
        S_TAP_RD,
        S_TAP_OUT
    } t_state;

endpackage

// ----- src/impulse_onset_align_top.sv -----
// ----------------------------------------------------------------------------
// Impulse onset align top level
// Stores one impulse response, finds its onset and emits the aligned taps.
// ----------------------------------------------------------------------------
// Samples load one per cycle while busy is low; a sample beyond the store
// depth is dropped and flagged. The item carrying final_sample raises busy
// until the last tap is out: the onset scan reads and then checks each
// examined entry in turn on the single registered memory read port and
// shared magnitude compare, then the onset result is issued and each tap
// is read and then output. Each result is shown on o_result for one cycle
// with o_strobe high and must be taken then; the receiver cannot hold
// results off. The last tap strobe lands in the cycle busy falls.
module impulse_onset_align_top
    import iao_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_in  i_data,
    output logic o_strobe,
    output t_out o_result
);

    t_mem_req            w_mem_req;
    logic [SAMPLE_W-1:0] w_rd_data;

    iao_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_in      (i_data),
        .o_busy    (busy),
        .o_mem_req (w_mem_req),
        .i_rd_data (w_rd_data),
        .o_strobe  (o_strobe),
        .o_out     (o_result)
    );

    iao_sample_mem u_mem (
        .i_clk     (i_clk),
        .i_req     (w_mem_req),
        .o_rd_data (w_rd_data)
    );

endmodule

// ----- src/iao_sample_mem.sv -----
// ----------------------------------------------------------------------------
// Impulse onset align sample memory
// Single write port, single registered read port sample store.
// ----------------------------------------------------------------------------
module iao_sample_mem
    import iao_pkg::*;
(
    input  logic                i_clk,
    input  t_mem_req            i_req,
    output logic [SAMPLE_W-1:0] o_rd_data
);

    logic [SAMPLE_W-1:0] r_mem [MAX_LEN];
    logic [SAMPLE_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rd_data <= r_mem[i_req.raddr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- src/iao_ctrl.sv -----
// ----------------------------------------------------------------------------
// Impulse onset align sequencer
// Loads samples, scans for the onset with a shared compare unit, emits taps.
// ----------------------------------------------------------------------------
`include "impulse_onset_align_top_macros.svh"

module iao_ctrl
    import iao_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  t_in                 i_in,
    output logic                o_busy,
    output t_mem_req            o_mem_req,
    input  logic [SAMPLE_W-1:0] i_rd_data,
    output logic                o_strobe,
    output t_out                o_out
);

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [MAG_W-1:0]    r_peak, n_peak;
    logic                r_drop, n_drop;
    logic [ADDR_W-1:0]   r_idx, n_idx;
    logic [ADDR_W-1:0]   r_onset, n_onset;
    logic [TAP_W-1:0]    r_tap, n_tap;
    logic                r_strobe, n_strobe;
    t_out                r_out, n_out;

    logic                w_accept;
    logic [MAG_W-1:0]    w_mag_in;
    logic [MAG_W-1:0]    w_mag_rd;
    logic [PROD_W-1:0]   w_prod;
    logic                w_hit;
    logic                w_scan_last;
    logic [SRC_W-1:0]    w_src;
    logic                w_tap_ok;
    logic                w_tap_last;

    function automatic logic [MAG_W-1:0] mag(input logic [SAMPLE_W-1:0] s);
        logic [MAG_W-1:0] w;
        w = {s[SAMPLE_W-1], s};
        return s[SAMPLE_W-1] ? (~w + MAG_W'(1)) : w;
    endfunction

    assign w_accept    = i_start && (r_state == S_LOAD);
    assign o_busy      = (r_state != S_LOAD);
    assign w_mag_in    = mag(i_in.sample);
    assign w_mag_rd    = mag(i_rd_data);
    assign w_prod      = (PROD_W'(w_mag_rd) << 3) + (PROD_W'(w_mag_rd) << 1);
    assign w_hit       = (w_prod >= PROD_W'(r_peak));
    assign w_scan_last = ((CNT_W'(r_idx) + CNT_W'(1)) >= r_count);
    assign w_src       = SRC_W'(r_onset) + SRC_W'(r_tap);
    assign w_tap_ok    = (w_src < SRC_W'(r_count));
    assign w_tap_last  = (r_tap == TAP_W'(TAPS - 1));

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_LOAD: begin
                if (w_accept && i_in.final_sample) begin
                    n_state = S_SCAN_RD;
                end
            end
            S_SCAN_RD:  n_state = S_SCAN_CHK;
            S_SCAN_CHK: begin
                if (w_hit || w_scan_last) begin
                    n_state = S_ONSET;
                end else begin
                    n_state = S_SCAN_RD;
                end
            end
            S_ONSET:    n_state = S_TAP_RD;
            S_TAP_RD:   n_state = S_TAP_OUT;
            S_TAP_OUT: begin
                if (w_tap_last) begin
                    n_state = S_LOAD;
                end else begin
                    n_state = S_TAP_RD;
                end
            end
            default:    n_state = S_LOAD;
        endcase
    end

    always_comb begin
        n_count  = r_count;
        n_peak   = r_peak;
        n_drop   = r_drop;
        n_idx    = r_idx;
        n_onset  = r_onset;
        n_tap    = r_tap;
        n_strobe = 1'b0;
        n_out    = r_out;
        o_mem_req.we    = 1'b0;
        o_mem_req.waddr = r_count[ADDR_W-1:0];
        o_mem_req.wdata = i_in.sample;
        o_mem_req.raddr = (r_state == S_TAP_RD) ? w_src[ADDR_W-1:0] : r_idx;
        case (r_state)
            S_LOAD: begin
                if (w_accept) begin
                    // store while room remains, otherwise drop and flag
                    if (r_count < CNT_W'(MAX_LEN)) begin
                        o_mem_req.we = 1'b1;
                        n_count      = r_count + CNT_W'(1);
                        if (w_mag_in > r_peak) begin
                            n_peak = w_mag_in;
                        end
                    end else begin
                        n_drop = 1'b1;
                    end
                    n_idx = '0;
                end
            end
            S_SCAN_CHK: begin
                if (w_hit) begin
                    n_onset = r_idx;
                end else if (w_scan_last) begin
                    n_onset = '0;
                end else begin
                    n_idx = r_idx + ADDR_W'(1);
                end
            end
            S_ONSET: begin
                n_strobe          = 1'b1;
                n_out.is_onset    = 1'b1;
                n_out.onset_index = ONSET_W'(r_onset);
                n_out.tap         = '0;
                n_out.overflow    = r_drop;
                n_out.end_of_run  = 1'b0;
                n_tap             = '0;
            end
            S_TAP_OUT: begin
                n_strobe          = 1'b1;
                n_out.is_onset    = 1'b0;
                n_out.onset_index = ONSET_W'(r_onset);
                n_out.tap         = w_tap_ok ? i_rd_data : '0;
                n_out.overflow    = r_drop;
                n_out.end_of_run  = w_tap_last;
                if (w_tap_last) begin
                    // clear run state for the next response
                    n_count = '0;
                    n_peak  = '0;
                    n_drop  = 1'b0;
                end else begin
                    n_tap = r_tap + TAP_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_count  <= '0;
            r_peak   <= '0;
            r_drop   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_peak   <= n_peak;
            r_drop   <= n_drop;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_onset <= n_onset;
        r_tap   <= n_tap;
        r_out   <= n_out;
    end

    assign o_strobe = r_strobe;
    assign o_out    = r_out;

    `IAO_ASSERT_IMPL(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(MAX_LEN))
    `IAO_ASSERT_IMPL(a_scan_in_range, i_clk, i_rst_n, r_state == S_SCAN_CHK,
                     CNT_W'(r_idx) < r_count)
    `IAO_ASSERT_NEXT(a_final_goes_busy, i_clk, i_rst_n,
                     w_accept && i_in.final_sample, o_busy)
    `IAO_ASSERT_IMPL(a_onset_then_taps, i_clk, i_rst_n, r_strobe && r_out.is_onset,
                     r_state == S_TAP_RD)
    `IAO_ASSERT_IMPL(a_end_is_tap, i_clk, i_rst_n, r_strobe && r_out.end_of_run,
                     !r_out.is_onset && (r_state == S_LOAD))

endmodule
